// ===== design/rlpi_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpi_pkg
// Shared types and constants of the run-length prefix index.
// ----------------------------------------------------------------------------
package rlpi_pkg;

    localparam int VAL_W = 15;
    localparam int LEN_W = 21;
    localparam int SUM_W = 35;
    localparam int POS_W = 20;
    localparam int RAW_W = 16;

    // Largest element total that the length registers can hold.
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_FILL   = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_LIMIT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_CALC,
        BS_MUL,
        BS_ACC
    } t_bstate;

    typedef struct packed {
        t_kind             kind;
        logic [VAL_W-1:0]  value;
        logic [LEN_W-1:0]  fill;
        logic [POS_W-1:0]  pos;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [SUM_W-1:0]  offset_sum;
        logic [VAL_W-1:0]  run_value;
    } t_result;

endpackage

// ===== design/rlpi_ram.sv =====
// ----------------------------------------------------------------------------
// rlpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlpi_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rlpi_front.sv =====
// ----------------------------------------------------------------------------
// rlpi_front
// Input queue: accepts items, decodes the kind and clamps the element value.
// ----------------------------------------------------------------------------
module rlpi_front
    import rlpi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [1:0]       i_kind,
    input  logic [RAW_W-1:0] i_element_value,
    input  logic [LEN_W-1:0] i_fill_count,
    input  logic [POS_W-1:0] i_position,
    output logic             o_valid,
    output t_item            o_item,
    input  logic             i_pop
);

    t_item      r_buf [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;
    t_item      w_item;
    logic       w_wr;
    logic       w_rd;

    // Negative element values become zero.
    always_comb begin
        w_item.kind  = t_kind'(i_kind);
        w_item.value = i_element_value[RAW_W-1] ? '0 : i_element_value[VAL_W-1:0];
        w_item.fill  = i_fill_count;
        w_item.pos   = i_position;
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_buf[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_rd ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, w_wr} - {1'b0, w_rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_buf[r_wr_ptr] <= w_item;
        end
    end

endmodule

// ===== design/rlpi_back.sv =====
// ----------------------------------------------------------------------------
// rlpi_back
// Executes items: keeps the run table, applies appends and fills, and walks
// the cursor forward over runs for queries with one shared multiplier.
// ----------------------------------------------------------------------------
module rlpi_back
    import rlpi_pkg::*;
#(
    parameter int RUN_DEPTH    = 4096,
    parameter int MAX_ELEMENTS = 1048576
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    input  logic    i_room,
    output logic    o_push,
    output t_result o_result
);

    localparam int IDX_W = $clog2(RUN_DEPTH);
    localparam int CNT_W = $clog2(RUN_DEPTH + 1);
    localparam int ENT_W = VAL_W + LEN_W;
    localparam int PRD_W = VAL_W + LEN_W;
    localparam logic [LEN_W-1:0] LIMIT =
        (MAX_ELEMENTS > 2097151) ? LEN_MAX : LEN_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RUN_DEPTH);

    t_bstate r_state, n_state;

    logic [CNT_W-1:0] r_run_count;
    logic [LEN_W-1:0] r_total;
    logic [VAL_W-1:0] r_last_val;
    logic [LEN_W-1:0] r_last_len;
    logic [LEN_W-1:0] r_cur_pos;
    logic [SUM_W-1:0] r_cur_sum;
    logic [CNT_W-1:0] r_cur_run;
    logic [LEN_W-1:0] r_cur_off;
    logic [LEN_W-1:0] r_tgt;
    logic [VAL_W-1:0] r_mul_val;
    logic [LEN_W-1:0] r_step;
    logic [PRD_W-1:0] r_prod;

    logic             w_take;
    logic             w_is_query;
    logic             w_in_range;
    logic             w_app_limit;
    logic             w_app_extend;
    logic             w_app_full;
    logic             w_fill_over;
    logic             w_ram_we;
    logic [IDX_W-1:0] w_waddr;
    logic [ENT_W-1:0] w_wdata;
    logic             w_ram_re;
    logic [ENT_W-1:0] w_rdata;
    logic [VAL_W-1:0] w_rd_val;
    logic [LEN_W-1:0] w_rd_len;
    logic [LEN_W-1:0] w_left;
    logic [LEN_W:0]   w_reach;
    logic             w_take_all;
    logic [LEN_W-1:0] w_step;
    logic             w_has_run;
    logic             w_done;
    logic [LEN_W-1:0] w_pos_ext;

    rlpi_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RUN_DEPTH)
    ) u_runs (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_cur_run[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Item classification.
    assign w_pos_ext    = {1'b0, i_item.pos};
    assign w_is_query   = (i_item.kind == KIND_QUERY);
    assign w_in_range   = (w_pos_ext < r_total);
    assign w_app_limit  = (r_total >= LIMIT);
    assign w_app_extend = (r_run_count != '0) && (r_last_val == i_item.value);
    assign w_app_full   = (r_run_count >= DEPTH_C);
    assign w_fill_over  = (i_item.fill > LIMIT);

    // Cursor step over the run just read.
    assign w_rd_val   = w_rdata[ENT_W-1:LEN_W];
    assign w_rd_len   = w_rdata[LEN_W-1:0];
    assign w_left     = w_rd_len - r_cur_off;
    assign w_reach    = {1'b0, r_cur_pos} + {1'b0, w_left};
    assign w_take_all = (w_reach <= {1'b0, r_tgt});
    assign w_step     = w_take_all ? w_left : (r_tgt - r_cur_pos);
    assign w_has_run  = (r_cur_run < r_run_count);
    assign w_done     = (r_cur_pos == r_tgt) || !w_has_run;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (w_take && w_is_query && w_in_range) begin
                    n_state = BS_READ;
                end
            end
            BS_READ: n_state = BS_CALC;
            BS_CALC: n_state = w_done ? BS_IDLE : BS_MUL;
            BS_MUL:  n_state = BS_ACC;
            BS_ACC:  n_state = BS_CALC;
            default: n_state = BS_IDLE;
        endcase
    end

    always_comb begin
        w_take   = 1'b0;
        o_push   = 1'b0;
        w_ram_re = 1'b0;
        w_ram_we = 1'b0;
        w_waddr  = '0;
        w_wdata  = {VAL_W'(1), i_item.fill};
        o_result = '{status: ST_OK, offset_sum: '0, run_value: '0};
        case (r_state)
            BS_IDLE: begin
                w_take = i_valid && i_room;
                o_push = w_take && !(w_is_query && w_in_range);
                case (i_item.kind)
                    KIND_APPEND: begin
                        if (w_app_limit) begin
                            o_result.status = ST_LIMIT;
                        end else if (w_app_extend) begin
                            w_ram_we = w_take;
                            w_waddr  = IDX_W'(r_run_count - CNT_W'(1));
                            w_wdata  = {r_last_val, r_last_len + LEN_W'(1)};
                        end else if (w_app_full) begin
                            o_result.status = ST_FULL;
                        end else begin
                            w_ram_we = w_take;
                            w_waddr  = r_run_count[IDX_W-1:0];
                            w_wdata  = {i_item.value, LEN_W'(1)};
                        end
                    end
                    KIND_FILL: begin
                        if (w_fill_over) begin
                            o_result.status = ST_LIMIT;
                        end else begin
                            w_ram_we = w_take && (i_item.fill != '0);
                        end
                    end
                    KIND_QUERY: begin
                        if (!w_in_range) begin
                            o_result.status = ST_RANGE;
                        end
                    end
                    default: ;
                endcase
            end
            BS_READ: w_ram_re = 1'b1;
            BS_CALC: begin
                o_push              = w_done;
                o_result.offset_sum = r_cur_sum;
                o_result.run_value  = w_has_run ? w_rd_val : '0;
            end
            BS_ACC:  w_ram_re = 1'b1;
            default: ;
        endcase
    end

    assign o_pop = w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_run_count <= '0;
            r_total     <= '0;
            r_cur_pos   <= '0;
            r_cur_sum   <= '0;
            r_cur_run   <= '0;
            r_cur_off   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                BS_IDLE: begin
                    if (w_take) begin
                        case (i_item.kind)
                            KIND_CLEAR: begin
                                r_run_count <= '0;
                                r_total     <= '0;
                                r_cur_pos   <= '0;
                                r_cur_sum   <= '0;
                                r_cur_run   <= '0;
                                r_cur_off   <= '0;
                            end
                            KIND_APPEND: begin
                                if (!w_app_limit) begin
                                    if (w_app_extend) begin
                                        r_total <= r_total + LEN_W'(1);
                                    end else if (!w_app_full) begin
                                        r_total     <= r_total + LEN_W'(1);
                                        r_run_count <= r_run_count + CNT_W'(1);
                                    end
                                end
                            end
                            KIND_FILL: begin
                                if (!w_fill_over) begin
                                    r_run_count <= (i_item.fill != '0) ? CNT_W'(1) : '0;
                                    r_total     <= i_item.fill;
                                    r_cur_pos   <= '0;
                                    r_cur_sum   <= '0;
                                    r_cur_run   <= '0;
                                    r_cur_off   <= '0;
                                end
                            end
                            KIND_QUERY: begin
                                // A query behind the cursor walks again from the start.
                                if (w_in_range && (w_pos_ext < r_cur_pos)) begin
                                    r_cur_pos <= '0;
                                    r_cur_sum <= '0;
                                    r_cur_run <= '0;
                                    r_cur_off <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                BS_CALC: begin
                    if (!w_done) begin
                        r_cur_pos <= r_cur_pos + w_step;
                        if (w_take_all) begin
                            r_cur_run <= r_cur_run + CNT_W'(1);
                            r_cur_off <= '0;
                        end else begin
                            r_cur_off <= r_cur_off + w_step;
                        end
                    end
                end
                BS_ACC: r_cur_sum <= r_cur_sum + r_prod[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    // Payload registers: the last run mirror, query target and multiplier path.
    always_ff @(posedge i_clk) begin
        if (r_state == BS_IDLE && w_take) begin
            r_tgt <= w_pos_ext;
            if (i_item.kind == KIND_APPEND && !w_app_limit) begin
                if (w_app_extend) begin
                    r_last_len <= r_last_len + LEN_W'(1);
                end else if (!w_app_full) begin
                    r_last_val <= i_item.value;
                    r_last_len <= LEN_W'(1);
                end
            end
            if (i_item.kind == KIND_FILL && !w_fill_over) begin
                r_last_val <= VAL_W'(1);
                r_last_len <= i_item.fill;
            end
        end
        if (r_state == BS_CALC) begin
            r_mul_val <= w_rd_val;
            r_step    <= w_step;
        end
        if (r_state == BS_MUL) begin
            r_prod <= r_mul_val * r_step;
        end
    end

endmodule

// ===== design/run_length_prefix_index.sv =====
// ----------------------------------------------------------------------------
// run_length_prefix_index
// Run-length table of record sizes with cursor-based prefix sum queries.
// ----------------------------------------------------------------------------
// Both sides look like a queue. An item is taken on push while full is low;
// the oldest result sits on the o_ result ports while empty is low and is
// taken on pop. Every item gives exactly one result, in item order.
// Clear, append and fill items are finished in the execution unit as they
// are taken, and so is a query whose position is out of range. A query in
// range steps the cursor over (or into) runs from the read state: each step
// is one run table read, one multiply and one accumulate, through the single
// read port of the run table and one shared multiplier. A result shows at
// best behind the input queue register and the output queue register.
// A two-entry queue on each side lets the input keep taking items while a
// result waits; when the receiver stalls, the output queue fills and then
// full rises once the input queue fills too.
// Reset empties both queues, the run table and the cursor at once; the
// table memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module run_length_prefix_index
    import rlpi_pkg::*;
#(
    parameter int RUN_DEPTH    = 4096,
    parameter int MAX_ELEMENTS = 1048576
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       i_kind,
    input  logic [RAW_W-1:0] i_element_value,
    input  logic [LEN_W-1:0] i_fill_count,
    input  logic [POS_W-1:0] i_position,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       o_status,
    output logic [SUM_W-1:0] o_offset_sum,
    output logic [VAL_W-1:0] o_run_value
);

    t_item      w_item;
    logic       w_item_valid;
    logic       w_item_pop;
    logic       w_res_push;
    t_result    w_result;
    t_result    r_obuf [2];
    logic       r_owr_ptr, n_owr_ptr;
    logic       r_ord_ptr, n_ord_ptr;
    logic [1:0] r_ocount,  n_ocount;
    logic       w_ord;

    rlpi_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_kind          (i_kind),
        .i_element_value (i_element_value),
        .i_fill_count    (i_fill_count),
        .i_position      (i_position),
        .o_valid         (w_item_valid),
        .o_item          (w_item),
        .i_pop           (w_item_pop)
    );

    rlpi_back #(
        .RUN_DEPTH    (RUN_DEPTH),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_item_valid),
        .i_item   (w_item),
        .o_pop    (w_item_pop),
        .i_room   (r_ocount != 2'd2),
        .o_push   (w_res_push),
        .o_result (w_result)
    );

    // Output queue. The back end takes an item only with a free slot, so a
    // push never meets a full queue.
    assign empty = (r_ocount == 2'd0);
    assign w_ord = pop && !empty;

    always_comb begin
        n_owr_ptr = w_res_push ? ~r_owr_ptr : r_owr_ptr;
        n_ord_ptr = w_ord ? ~r_ord_ptr : r_ord_ptr;
        n_ocount  = r_ocount + {1'b0, w_res_push} - {1'b0, w_ord};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr_ptr <= 1'b0;
            r_ord_ptr <= 1'b0;
            r_ocount  <= 2'd0;
        end else begin
            r_owr_ptr <= n_owr_ptr;
            r_ord_ptr <= n_ord_ptr;
            r_ocount  <= n_ocount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_obuf[r_owr_ptr] <= w_result;
        end
    end

    assign o_status     = r_obuf[r_ord_ptr].status;
    assign o_offset_sum = r_obuf[r_ord_ptr].offset_sum;
    assign o_run_value  = r_obuf[r_ord_ptr].run_value;

endmodule

// ===== sim/rlpi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpi_checker
// Watches both queues of the run-length prefix index. It keeps its own copy of
// the run table and the cursor, works out the result of every accepted item,
// and compares each popped result with the oldest one that is due.
// ----------------------------------------------------------------------------
module rlpi_checker
    import rlpi_pkg::*;
#(
    parameter int RUN_DEPTH    = 4096,
    parameter int MAX_ELEMENTS = 1048576
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_full,
    input  logic [1:0]       i_kind,
    input  logic [RAW_W-1:0] i_element_value,
    input  logic [LEN_W-1:0] i_fill_count,
    input  logic [POS_W-1:0] i_position,
    input  logic             i_empty,
    input  logic             i_pop,
    input  logic [1:0]       i_status,
    input  logic [SUM_W-1:0] i_offset_sum,
    input  logic [VAL_W-1:0] i_run_value,
    output int               o_fail_count,
    output int               o_waiting
);

    // The element total is held in LEN_W bits, so the limit can not go above that.
    localparam int unsigned ELEM_LIMIT =
        (MAX_ELEMENTS > int'(LEN_MAX)) ? int'(LEN_MAX) : MAX_ELEMENTS;

    logic [VAL_W-1:0] run_vals [RUN_DEPTH];
    logic [LEN_W-1:0] run_lens [RUN_DEPTH];
    int unsigned      run_cnt;
    int unsigned      elem_cnt;
    int unsigned      cur_pos;
    int unsigned      cur_run;
    int unsigned      cur_off;
    logic [SUM_W-1:0] cur_sum;

    t_result          due_results [$];

    function automatic void rewind_cursor();
        cur_pos = 0;
        cur_run = 0;
        cur_off = 0;
        cur_sum = '0;
    endfunction

    // Applies one item to the table copy and returns the result it must give.
    function automatic t_result index_step(t_kind kind, logic [RAW_W-1:0] raw,
                                           logic [LEN_W-1:0] fill,
                                           logic [POS_W-1:0] pos);
        t_result          res;
        logic [VAL_W-1:0] v;
        int unsigned      remain;
        int unsigned      step;
        logic [63:0]      prod;
        res.status     = ST_OK;
        res.offset_sum = '0;
        res.run_value  = '0;
        case (kind)
            KIND_CLEAR: begin
                run_cnt  = 0;
                elem_cnt = 0;
                rewind_cursor();
            end
            KIND_APPEND: begin
                v = raw[RAW_W-1] ? '0 : raw[VAL_W-1:0];
                if (elem_cnt >= ELEM_LIMIT) begin
                    res.status = ST_LIMIT;
                end else if (run_cnt > 0 && run_vals[run_cnt-1] == v) begin
                    run_lens[run_cnt-1] = run_lens[run_cnt-1] + 1'b1;
                    elem_cnt++;
                end else if (run_cnt >= RUN_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    run_vals[run_cnt] = v;
                    run_lens[run_cnt] = 1;
                    run_cnt++;
                    elem_cnt++;
                end
            end
            KIND_FILL: begin
                if (fill > ELEM_LIMIT) begin
                    res.status = ST_LIMIT;
                end else begin
                    if (fill == 0) begin
                        run_cnt = 0;
                    end else begin
                        run_vals[0] = 1;
                        run_lens[0] = fill;
                        run_cnt     = 1;
                    end
                    elem_cnt = fill;
                    rewind_cursor();
                end
            end
            default: begin
                if (pos >= elem_cnt) begin
                    res.status = ST_RANGE;
                end else begin
                    if (pos < cur_pos)
                        rewind_cursor();
                    // Either swallow the rest of the current run or stop inside it.
                    while (cur_pos < pos && cur_run < run_cnt) begin
                        remain = run_lens[cur_run] - cur_off;
                        if (cur_pos + remain <= pos) begin
                            step    = remain;
                            prod    = 64'(run_vals[cur_run]) * 64'(step);
                            cur_run = cur_run + 1;
                            cur_off = 0;
                        end else begin
                            step    = pos - cur_pos;
                            prod    = 64'(run_vals[cur_run]) * 64'(step);
                            cur_off = cur_off + step;
                        end
                        cur_sum = cur_sum + prod[SUM_W-1:0];
                        cur_pos = cur_pos + step;
                    end
                    res.offset_sum = cur_sum;
                    if (cur_run < run_cnt)
                        res.run_value = run_vals[cur_run];
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            run_cnt  = 0;
            elem_cnt = 0;
            rewind_cursor();
            due_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (due_results.size() == 0) begin
                    $error("result with no item waiting: status %0d, offset_sum %0d, run_value %0d",
                           i_status, i_offset_sum, i_run_value);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_offset_sum !== want.offset_sum) begin
                        $error("offset_sum mismatch: expected %0d, got %0d",
                               want.offset_sum, i_offset_sum);
                        o_fail_count++;
                    end
                    if (i_run_value !== want.run_value) begin
                        $error("run_value mismatch: expected %0d, got %0d",
                               want.run_value, i_run_value);
                        o_fail_count++;
                    end
                end
            end
            if (i_push && !i_full)
                due_results.insert(due_results.size(),
                                   index_step(t_kind'(i_kind), i_element_value,
                                              i_fill_count, i_position));
        end
        o_waiting = due_results.size();
    end

endmodule

// ===== sim/tb_run_length_prefix_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_length_prefix_index
// Drives clear, append, fill and query items into the run-length prefix index
// with random gaps and receiver stalls: a directed opening, then random table
// builds with mostly forward queries. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_run_length_prefix_index;
    import rlpi_pkg::*;

    localparam int          RUN_DEPTH    = 4096;
    localparam int          MAX_ELEMENTS = 1048576;
    localparam int unsigned ELEM_CAP     = MAX_ELEMENTS;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned QUIET_TAIL   = 150;

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    logic [1:0]       i_kind;
    logic [RAW_W-1:0] i_element_value;
    logic [LEN_W-1:0] i_fill_count;
    logic [POS_W-1:0] i_position;
    logic             empty;
    logic             pop;
    logic [1:0]       o_status;
    logic [SUM_W-1:0] o_offset_sum;
    logic [VAL_W-1:0] o_run_value;

    int               fail_count;
    int               waiting;
    bit               quiet;
    int unsigned      items_issued;
    int unsigned      table_len;
    int unsigned      last_query;

    run_length_prefix_index #(
        .RUN_DEPTH   (RUN_DEPTH),
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_kind         (i_kind),
        .i_element_value(i_element_value),
        .i_fill_count   (i_fill_count),
        .i_position     (i_position),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_offset_sum   (o_offset_sum),
        .o_run_value    (o_run_value)
    );

    rlpi_checker #(
        .RUN_DEPTH   (RUN_DEPTH),
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_kind         (i_kind),
        .i_element_value(i_element_value),
        .i_fill_count   (i_fill_count),
        .i_position     (i_position),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_status       (o_status),
        .i_offset_sum   (o_offset_sum),
        .i_run_value    (o_run_value),
        .o_fail_count   (fail_count),
        .o_waiting      (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: long stretches of popping broken by stall bursts.
    initial begin
        pop <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // Returns at the rising edge at which the item is taken; push stays high.
    task automatic issue_item(t_kind kind, logic [RAW_W-1:0] value,
                              logic [LEN_W-1:0] fill, logic [POS_W-1:0] pos);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            push            <= 1'b0;
            i_kind          <= 2'($urandom);
            i_element_value <= RAW_W'($urandom);
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_kind          <= kind;
        i_element_value <= value;
        i_fill_count    <= fill;
        i_position      <= pos;
        do @(posedge i_clk); while (full);
        items_issued++;
    endtask

    task automatic do_clear();
        issue_item(KIND_CLEAR, RAW_W'($urandom), LEN_W'($urandom), POS_W'($urandom));
        table_len = 0;
    endtask

    task automatic do_append(logic [RAW_W-1:0] value);
        issue_item(KIND_APPEND, value, LEN_W'($urandom), POS_W'($urandom));
        if (table_len < ELEM_CAP)
            table_len++;
    endtask

    task automatic do_fill(logic [LEN_W-1:0] count);
        issue_item(KIND_FILL, RAW_W'($urandom), count, POS_W'($urandom));
        if (count <= ELEM_CAP) begin
            table_len  = count;
            last_query = 0;
        end
    endtask

    task automatic do_query(logic [POS_W-1:0] pos);
        issue_item(KIND_QUERY, RAW_W'($urandom), LEN_W'($urandom), pos);
        last_query = pos;
    endtask

    // Holds the sender back until every result due has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (waiting != 0);
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned      base;
        int unsigned      sel;
        int unsigned      cnt;
        int unsigned      nxt;

        quiet           = 1'b0;
        items_issued    = 0;
        table_len       = 0;
        last_query      = 0;
        i_rst_n         <= 1'b0;
        push            <= 1'b0;
        i_kind          <= KIND_CLEAR;
        i_element_value <= '0;
        i_fill_count    <= '0;
        i_position      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: empty table, clamping, run merging, limits.
        do_query(POS_W'(0));
        do_append(16'hFFFB);
        do_append(16'h0000);
        do_append(16'h7FFF);
        do_append(16'h7FFF);
        do_append(16'h0001);
        do_append(16'h8000);
        do_query(POS_W'(3));
        do_query(POS_W'(5));
        do_query(POS_W'(1));
        do_query(POS_W'(6));
        do_query({POS_W{1'b1}});
        do_fill(LEN_W'(0));
        do_query(POS_W'(0));
        do_fill({LEN_W{1'b1}});
        do_fill(LEN_W'(ELEM_CAP + 1));
        do_fill(LEN_W'(ELEM_CAP));
        do_append(16'h0001);
        do_query(POS_W'(ELEM_CAP - 1));
        do_query(POS_W'(0));
        do_fill(LEN_W'(ELEM_CAP - 1));
        do_append(16'h0007);
        do_append(16'h0007);
        do_query(POS_W'(ELEM_CAP - 1));
        do_clear();
        do_query(POS_W'(0));
        wait_drained();

        do_clear();
        base = items_issued;
        while (items_issued - base < RANDOM_ITEMS) begin
            quiet = (items_issued - base >= RANDOM_ITEMS - QUIET_TAIL);
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                do_clear();
            end else if (sel < 30) begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    do_fill(LEN_W'($urandom_range(0, 40)));
                else if (sel < 8)
                    do_fill(LEN_W'($urandom_range(0, ELEM_CAP)));
                else if (sel == 8)
                    do_fill(LEN_W'(ELEM_CAP + $urandom_range(0, 1)));
                else
                    do_fill(LEN_W'($urandom));
            end
            cnt = $urandom_range(0, 12);
            repeat (cnt) begin
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    do_append(RAW_W'($urandom_range(0, 3)));
                else if (sel < 6)
                    do_append(RAW_W'($urandom_range(32768, 65535)));
                else if (sel < 7)
                    do_append(16'h7FFF);
                else
                    do_append(RAW_W'($urandom));
            end
            cnt = $urandom_range(1, 10);
            repeat (cnt) begin
                sel = $urandom_range(0, 9);
                if (table_len == 0 || sel == 0) begin
                    do_query(POS_W'($urandom));
                end else if (sel == 1) begin
                    do_query(POS_W'(table_len - 1));
                end else if (sel == 2) begin
                    do_query(POS_W'($urandom_range(0, table_len - 1)));
                end else begin
                    // Mostly small forward steps so the cursor resumes.
                    nxt = (last_query < table_len) ? last_query : 0;
                    nxt = nxt + $urandom_range(0, (sel < 7) ? 4 : table_len / 4 + 1);
                    if (nxt >= table_len)
                        nxt = table_len - 1;
                    do_query(POS_W'(nxt));
                end
            end
            if (!quiet && $urandom_range(0, 49) == 0)
                wait_drained();
        end

        quiet = 1'b1;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
